// ===== hw/rtl/kpg_pkg.sv =====
// Shared types, phrase tables and character helpers for keyword_phrase_gate.
// No dependencies; used by kpg_match and keyword_phrase_gate.
package kpg_pkg;

    localparam int PHRASE_MAX = 17;
    localparam int LEN_W      = 5;
    localparam int REL_COUNT  = 23;
    localparam int DET_COUNT  = 8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // newest character in the lowest byte, zero padded above the phrase
    typedef logic [8*PHRASE_MAX-1:0] t_phrase_text;
    typedef logic [LEN_W-1:0]        t_phrase_len;

    typedef struct packed {
        logic rel;
        logic det;
    } t_hits;

    localparam t_phrase_text REL_TEXT [REL_COUNT] = '{
        t_phrase_text'("what do you see"), t_phrase_text'("can you see"),
        t_phrase_text'("do you see"),      t_phrase_text'("what am i holding"),
        t_phrase_text'("am i holding"),    t_phrase_text'("holding"),
        t_phrase_text'("what is this"),    t_phrase_text'("what is that"),
        t_phrase_text'("look"),            t_phrase_text'("look at"),
        t_phrase_text'("look around"),     t_phrase_text'("around me"),
        t_phrase_text'("in front of me"),  t_phrase_text'("on my desk"),
        t_phrase_text'("on the desk"),     t_phrase_text'("see"),
        t_phrase_text'("camera"),          t_phrase_text'("gesture"),
        t_phrase_text'("hand"),            t_phrase_text'("object"),
        t_phrase_text'("environment"),     t_phrase_text'("room"),
        t_phrase_text'("desk")
    };

    localparam t_phrase_len REL_LEN [REL_COUNT] = '{
        5'd15, 5'd11, 5'd10, 5'd17, 5'd12, 5'd7, 5'd12, 5'd12, 5'd4, 5'd7, 5'd11, 5'd9,
        5'd14, 5'd10, 5'd11, 5'd3, 5'd6, 5'd7, 5'd4, 5'd6, 5'd11, 5'd4, 5'd4
    };

    localparam t_phrase_text DET_TEXT [DET_COUNT] = '{
        t_phrase_text'("which object"),  t_phrase_text'("what objects"),
        t_phrase_text'("list objects"),  t_phrase_text'("what gesture"),
        t_phrase_text'("which gesture"), t_phrase_text'("show raw"),
        t_phrase_text'("details"),       t_phrase_text'("confidence")
    };

    localparam t_phrase_len DET_LEN [DET_COUNT] = '{
        5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd8, 5'd7, 5'd10
    };

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_D0 && c <= CHAR_D9);
    endfunction

endpackage

// ===== hw/rtl/keyword_phrase_gate.sv =====
// Top level of keyword_phrase_gate: normalizer, chain of window cells, phrase matcher.
// Depends on kpg_pkg, kpg_cell and kpg_match.
//
// Usage: stream one text byte per transfer on the slave side. tuser marks a real
// character (0 = no character, e.g. an empty utterance). tlast closes the utterance;
// the three context flags in tdata are only looked at on that transfer.
// Letters fold to lower case, runs of non-alphanumeric bytes (128-255 included) become one space.
// Each character shifts through a chain of WINDOW_LEN cells; the phrase compare runs on
// the shifted window in the same cycle and sets sticky hit flags.
// Throughput: one byte per cycle while the master side is not stalled. The verdict
// appears on the master side in the cycle after the tlast transfer, as a single transfer
// with inject, vision_relevant and needs_details. Non-last bytes give no output.
// Reset clears the window, the hit flags and the output valid flag; the end of every
// utterance does the same for the window and flags. A stalled master side holds the
// verdict; the slave side keeps taking bytes while the output register is empty or
// being drained in the same cycle.
module keyword_phrase_gate #(
    parameter int WINDOW_LEN = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] char_code, [8] has_fresh_snapshot,
                                    // [9] explicit_mode, [10] recent_gesture, [15:11] zero
    input  logic        i_s_tuser,  // [0] char_valid
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata   // [0] inject, [1] vision_relevant, [2] needs_details,
                                    // [7:3] zero
);

    logic           acc;
    logic [7:0]     w_char;
    logic           w_word;
    logic           w_shift;
    logic [7:0]     w_shift_char;
    logic [7:0]     w_win  [WINDOW_LEN];
    logic [7:0]     w_cand [WINDOW_LEN];
    kpg_pkg::t_hits w_hits;

    logic r_prev_sep, n_prev_sep;
    logic r_rel, n_rel;
    logic r_det, n_det;
    logic r_m_valid, n_m_valid;
    logic [2:0] r_m_data, n_m_data;
    logic w_rel_now, w_det_now;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;

    assign w_char       = kpg_pkg::fold_case(i_s_tdata[7:0]);
    assign w_word       = kpg_pkg::is_word_char(w_char);
    assign w_shift      = acc && i_s_tuser && (w_word || !r_prev_sep);
    assign w_shift_char = w_word ? w_char : kpg_pkg::CHAR_SPACE;

    assign w_cand[0] = w_shift_char;
    for (genvar g = 1; g < WINDOW_LEN; g++) begin : g_cand
        assign w_cand[g] = w_win[g-1];
    end

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        kpg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_clr   (acc && i_s_tlast),
            .i_data  (w_cand[g]),
            .o_data  (w_win[g])
        );
    end

    kpg_match #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_match (
        .i_win  (w_cand),
        .o_hits (w_hits)
    );

    assign w_rel_now = r_rel || (w_shift && w_hits.rel);
    assign w_det_now = r_det || (w_shift && w_hits.det);

    always_comb begin
        n_prev_sep = r_prev_sep;
        n_rel      = r_rel;
        n_det      = r_det;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_data   = r_m_data;
        if (acc) begin
            if (i_s_tuser) begin
                if (w_word) begin
                    n_prev_sep = 1'b0;
                end else begin
                    n_prev_sep = 1'b1;
                end
            end
            n_rel = w_rel_now;
            n_det = w_det_now;
            if (i_s_tlast) begin
                n_m_valid   = 1'b1;
                n_m_data[0] = i_s_tdata[8] && (i_s_tdata[9] || i_s_tdata[10] || w_rel_now);
                n_m_data[1] = w_rel_now;
                n_m_data[2] = w_det_now;
                n_prev_sep  = 1'b1;
                n_rel       = 1'b0;
                n_det       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sep <= 1'b1;
            r_rel      <= 1'b0;
            r_det      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_prev_sep <= n_prev_sep;
            r_rel      <= n_rel;
            r_det      <= n_det;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_m_data};

endmodule

// ===== hw/rtl/kpg_cell.sv =====
// One window cell: holds a normalized character, takes its neighbor's on shift, clears on i_clr.
// No dependencies.
module kpg_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clr,
    input  logic [7:0] i_data,
    output logic [7:0] o_data
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_clr) begin
            n_data = '0;
        end else if (i_shift) begin
            n_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/kpg_match.sv =====
// Compares the candidate window tail against both phrase lists.
// Depends on kpg_pkg for the phrase tables and the hit struct.
module kpg_match #(
    parameter int WINDOW_LEN = 17
) (
    input  logic [7:0]     i_win [WINDOW_LEN],
    output kpg_pkg::t_hits o_hits
);

    logic [kpg_pkg::REL_COUNT-1:0] w_rel;
    logic [kpg_pkg::DET_COUNT-1:0] w_det;

    always_comb begin
        w_rel = '1;
        for (int k = 0; k < kpg_pkg::REL_COUNT; k++) begin
            for (int i = 0; i < kpg_pkg::PHRASE_MAX; i++) begin
                if (kpg_pkg::LEN_W'(i) < kpg_pkg::REL_LEN[k] &&
                    i_win[i] != kpg_pkg::REL_TEXT[k][8*i +: 8]) begin
                    w_rel[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_det = '1;
        for (int k = 0; k < kpg_pkg::DET_COUNT; k++) begin
            for (int i = 0; i < kpg_pkg::PHRASE_MAX; i++) begin
                if (kpg_pkg::LEN_W'(i) < kpg_pkg::DET_LEN[k] &&
                    i_win[i] != kpg_pkg::DET_TEXT[k][8*i +: 8]) begin
                    w_det[k] = 1'b0;
                end
            end
        end
    end

    assign o_hits.rel = |w_rel;
    assign o_hits.det = |w_det;

endmodule

// ===== tb/keyword_phrase_gate_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyword_phrase_gate: streams utterances, predicts each verdict.
// Depends on the keyword_phrase_gate RTL (and kpg_pkg through it).
module keyword_phrase_gate_test;

    localparam int WINDOW_LEN  = 17;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [7:0] char_code, [8] has_fresh_snapshot,
                                   // [9] explicit_mode, [10] recent_gesture, [15:11] zero
    logic        i_s_tuser = 1'b0; // [0] char_valid
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [0] inject, [1] vision_relevant, [2] needs_details

    int unsigned src_idle_pct = 6;
    int unsigned snk_idle_pct = 74;
    logic        snk_hold = 1'b0;
    int unsigned phase = 1;
    int unsigned items_sent = 0;
    int unsigned idle_cycles = 0;
    logic [7:0]  text_q [$];

    string word_pool [44] = '{
        "what do you see", "can you see", "do you see", "what am i holding",
        "am i holding", "holding", "what is this", "what is that", "look", "look at",
        "look around", "around me", "in front of me", "on my desk", "on the desk",
        "see", "camera", "gesture", "hand", "object", "environment", "room", "desk",
        "which object", "what objects", "list objects", "what gesture", "which gesture",
        "show raw", "details", "confidence", "please", "the", "hey", "tell me about",
        "it", "lo", "ok", "cam", "detail", "show", "raw", "x9", "42"
    };

    class verdict_scoreboard;
        logic [7:0]  window [WINDOW_LEN];
        logic        prev_sep;
        logic        rel_hit;
        logic        det_hit;
        logic [7:0]  verdicts [$];
        int unsigned mismatches;
        string       rel_phrases [$];
        string       det_phrases [$];

        function new();
            rel_phrases = '{
                "what do you see", "can you see", "do you see", "what am i holding",
                "am i holding", "holding", "what is this", "what is that", "look",
                "look at", "look around", "around me", "in front of me", "on my desk",
                "on the desk", "see", "camera", "gesture", "hand", "object",
                "environment", "room", "desk"
            };
            det_phrases = '{
                "which object", "what objects", "list objects", "what gesture",
                "which gesture", "show raw", "details", "confidence"
            };
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (window[i]) window[i] = 8'h00;
            prev_sep = 1'b1;
            rel_hit  = 1'b0;
            det_hit  = 1'b0;
        endfunction

        function logic tail_is(string p);
            int n;
            n = p.len();
            if (n == 0 || n > WINDOW_LEN) return 1'b0;
            for (int i = 0; i < n; i++) begin
                if (window[i] != p[n-1-i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void shift_char(logic [7:0] c);
            for (int i = WINDOW_LEN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = c;
            foreach (rel_phrases[k]) if (tail_is(rel_phrases[k])) rel_hit = 1'b1;
            foreach (det_phrases[k]) if (tail_is(det_phrases[k])) det_hit = 1'b1;
        endfunction

        function void note_input(logic [7:0] code, logic cv, logic lst, logic [2:0] ctx);
            logic [7:0] c;
            logic       inject;
            c = code;
            if (cv) begin
                if (c >= "A" && c <= "Z") c = c + 8'd32;
                if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
                    shift_char(c);
                    prev_sep = 1'b0;
                end else if (!prev_sep) begin
                    shift_char(" ");
                    prev_sep = 1'b1;
                end
            end
            if (lst) begin
                inject = ctx[0] && (ctx[1] || ctx[2] || rel_hit);
                verdicts.push_back({5'b0, det_hit, rel_hit, inject});
                clear();
            end
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict %02h with nothing pending", got);
                return;
            end
            want = verdicts.pop_front();
            if (got[0] !== want[0] || got[1] !== want[1] || got[2] !== want[2] ||
                got[7:3] !== want[7:3]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp/got: inject %b/%b rel %b/%b det %b/%b pad %h/%h",
                             want[0], got[0], want[1], got[1], want[2], got[2],
                             want[7:3], got[7:3]);
            end
        endfunction
    endclass

    verdict_scoreboard sb = new();

    keyword_phrase_gate #(.WINDOW_LEN(WINDOW_LEN)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (snk_hold) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stall the result side long enough to back up the input
    initial begin
        wait (phase == 3);
        @(posedge i_clk);
        snk_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        snk_hold <= 1'b0;
    end

    task automatic send_item(input logic [7:0] code, input logic cv, input logic lst,
                             input logic [2:0] ctx);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, ctx, code};
        i_s_tuser  <= cv;
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(code, cv, lst, ctx);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic [2:0] ctx, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, close && (i == s.len() - 1), ctx);
    endtask

    function automatic void push_separators();
        string punct;
        int    n;
        punct = " ,.?!-_'";
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(3))
                0: text_q.push_back(" ");
                1: text_q.push_back(punct[$urandom_range(punct.len() - 1)]);
                2: text_q.push_back(8'($urandom_range(128, 255)));
                default: text_q.push_back(8'($urandom_range(0, 47)));
            endcase
        end
    endfunction

    task automatic send_random_utterance();
        string      w;
        int         nwords;
        logic [7:0] c;
        logic [2:0] ctx;
        logic       empty_close;
        text_q.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0) push_separators();
            nwords = $urandom_range(1, 4);
            for (int k = 0; k < nwords; k++) begin
                if (k != 0) push_separators();
                w = word_pool[$urandom_range($size(word_pool) - 1)];
                for (int j = 0; j < w.len(); j++) begin
                    c = w[j];
                    if (c == " ") begin
                        push_separators();
                    end else begin
                        if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'd32;
                        text_q.push_back(c);
                    end
                end
            end
            if ($urandom_range(3) == 0) push_separators();
        end
        ctx = 3'($urandom_range(7));
        empty_close = (text_q.size() == 0) || ($urandom_range(9) == 0);
        foreach (text_q[i]) begin
            if ($urandom_range(19) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 3'($urandom_range(7)));
            send_item(text_q[i], 1'b1, !empty_close && (i == text_q.size() - 1),
                      (i == text_q.size() - 1) ? ctx : 3'($urandom_range(7)));
        end
        if (empty_close) send_item(8'($urandom_range(255)), 1'b0, 1'b1, ctx);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(8'hFF, 1'b0, 1'b1, 3'b111);
        send_text("  LoOk", 3'b001, 1'b1);
        send_text("Show", 3'b110, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 3'b110);
        send_item(8'hFF, 1'b1, 1'b0, 3'b110);
        send_text("raw!", 3'b110, 1'b1);
        send_text("se", 3'b101, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0, 3'b101);
        send_text("e", 3'b101, 1'b1);
        send_item(8'h00, 1'b1, 1'b0, 3'b011);
        send_text("09", 3'b011, 1'b1);

        while (items_sent < PHASE_ITEMS) send_random_utterance();
        src_idle_pct <= 74;
        snk_idle_pct <= 6;
        while (items_sent < 2 * PHASE_ITEMS) send_random_utterance();
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        phase <= 3;
        while (items_sent < 3 * PHASE_ITEMS) send_random_utterance();

        i_s_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== keyword_phrase_gate.f =====
hw/rtl/kpg_pkg.sv
hw/rtl/kpg_cell.sv
hw/rtl/kpg_match.sv
hw/rtl/keyword_phrase_gate.sv
tb/keyword_phrase_gate_test.sv
